>>> rtl/core/mhpq_pkg.sv
// Shared types, widths and codes for the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_WIDTH        = 32;
    localparam int VALUE_WIDTH      = 32;
    localparam int COUNT_WIDTH      = 9;
    localparam int STATUS_WIDTH     = 2;
    localparam int DEFAULT_CAPACITY = 256;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_WIDTH       = $clog2(QUEUE_DEPTH);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                   kind;
        logic [KEY_WIDTH-1:0]   in_key;
        logic [VALUE_WIDTH-1:0] in_val;
    } cmd_item_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]    out_key;
        logic [VALUE_WIDTH-1:0]  out_val;
        logic [COUNT_WIDTH-1:0]  entry_count;
        logic [STATUS_WIDTH-1:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic                   op;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
    } op_cmd_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
    } entry_t;

endpackage

>>> rtl/core/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue of key/value pairs.
//
// Usage: each item on the cmd channel is an insert (kind 0) of in_key/in_val
// or a pop (kind 1) of the largest key. Every item produces exactly one item
// on the rsp channel, in order: the popped pair on pop, the root pair after an
// insert, the entry count after the operation and a status code (ok, insert
// rejected because full, pop rejected because empty).
// Both channels use valid/stall; an item moves when valid is high and stall low.
// A command passes a one-item input register and a four-item queue, then a
// sequencer sifts it through the heap memory level by level. One item is sifted
// at a time, so throughput is set by the sift loop on the memory ports.
// Commands keep flowing into the queue while a result waits in the output
// register; a stalled receiver backs up the result, then the queue, then cmd.
// Reset empties the heap and the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mhpq_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mhpq_pkg::rsp_item_t rsp
);

    logic              q_full;
    logic              q_push;
    mhpq_pkg::op_cmd_t q_data;
    logic              head_valid;
    logic              head_pop;
    mhpq_pkg::op_cmd_t head;

    mhpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    mhpq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .full       (q_full),
        .push_data  (q_data),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_data  (head)
    );

    mhpq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

>>> rtl/core/mhpq_front.sv
// Front stage that accepts command items and classifies them into heap operations.
`timescale 1ns / 1ps

module mhpq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mhpq_pkg::cmd_item_t cmd,
    input  logic                q_full,
    output logic                q_push,
    output mhpq_pkg::op_cmd_t   q_data
);

    logic              hold_valid_reg;
    logic              hold_valid_next;
    mhpq_pkg::op_cmd_t hold_reg;
    logic              accept;

    assign cmd_stall = hold_valid_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign q_push    = hold_valid_reg && !q_full;
    assign q_data    = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.op  <= (cmd.kind == mhpq_pkg::KIND_POP) ? mhpq_pkg::OP_POP
                                                             : mhpq_pkg::OP_INSERT;
            hold_reg.key <= cmd.in_key;
            hold_reg.val <= cmd.in_val;
        end
    end

endmodule

>>> rtl/core/mhpq_queue.sv
// Short command queue between the front stage and the heap engine.
`timescale 1ns / 1ps

module mhpq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              full,
    input  mhpq_pkg::op_cmd_t push_data,
    input  logic              pop,
    output logic              head_valid,
    output mhpq_pkg::op_cmd_t head_data
);

    localparam int PW = mhpq_pkg::QPTR_WIDTH;

    mhpq_pkg::op_cmd_t slot_reg [mhpq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       fill_reg;
    logic [PW:0]       fill_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (fill_reg == (PW+1)'(mhpq_pkg::QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/mhpq_back.sv
// Heap engine: entry memory, sift-up and sift-down sequencer, and result register.
`timescale 1ns / 1ps

module mhpq_back #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mhpq_pkg::op_cmd_t   head,
    output logic                head_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mhpq_pkg::rsp_item_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_REQ = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_POP_RD = 3'd3;
    localparam logic [2:0] S_POP_LD = 3'd4;
    localparam logic [2:0] S_DN_REQ = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    mhpq_pkg::entry_t mem [CAPACITY];

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [AW-1:0]                     par_reg, par_next;
    logic [AW-1:0]                     l_reg, l_next;
    logic [AW-1:0]                     r_reg, r_next;
    logic                              has_r_reg, has_r_next;
    logic                              op_reg, op_next;
    logic [mhpq_pkg::STATUS_WIDTH-1:0] status_reg, status_next;
    mhpq_pkg::entry_t                  mov_reg, mov_next;
    mhpq_pkg::entry_t                  res_reg, res_next;
    mhpq_pkg::entry_t                  root_reg;
    mhpq_pkg::entry_t                  rd_a_reg;
    mhpq_pkg::entry_t                  rd_b_reg;
    logic                              rsp_valid_reg, rsp_valid_next;
    mhpq_pkg::rsp_item_t               rsp_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    mhpq_pkg::entry_t wr_data;
    logic [AW-1:0]    rd_a_addr;
    logic [AW-1:0]    rd_b_addr;
    logic             emit;

    logic [IW-1:0]    l_idx;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    cnt_ext;
    logic             pick_right;
    mhpq_pkg::entry_t pick;
    logic [AW-1:0]    pick_idx;

    assign l_idx      = {1'b0, pos_reg, 1'b1};
    assign r_idx      = l_idx + 1'b1;
    assign cnt_ext    = IW'(count_reg);
    assign pick_right = has_r_reg && !(rd_a_reg.key > rd_b_reg.key);
    assign pick       = pick_right ? rd_b_reg : rd_a_reg;
    assign pick_idx   = pick_right ? r_reg : l_reg;
    assign emit       = (state_reg == S_EMIT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        par_next    = par_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        has_r_next  = has_r_reg;
        op_next     = op_reg;
        status_next = status_reg;
        mov_next    = mov_reg;
        res_next    = res_reg;
        head_pop    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = mov_reg;
        rd_a_addr   = '0;
        rd_b_addr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    head_pop    = 1'b1;
                    op_next     = head.op;
                    status_next = mhpq_pkg::STATUS_OK;
                    if (head.op == mhpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::STATUS_FULL;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            mov_next.key = head.key;
                            mov_next.val = head.val;
                            pos_next     = count_reg[AW-1:0];
                            count_next   = count_reg + 1'b1;
                            state_next   = S_UP_REQ;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::STATUS_EMPTY;
                            res_next    = '0;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            res_next   = root_reg;
                            count_next = count_reg - 1'b1;
                            state_next = (count_reg == CW'(1)) ? S_EMIT : S_POP_RD;
                        end
                    end
                end
            end

            S_UP_REQ:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    par_next   = AW'(pos_reg - 1'b1) >> 1;
                    rd_a_addr  = par_next;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_reg.key >= mov_reg.key)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    wr_data    = rd_a_reg;
                    pos_next   = par_reg;
                    state_next = S_UP_REQ;
                end
            end

            S_POP_RD:
            begin
                rd_a_addr  = count_reg[AW-1:0];
                state_next = S_POP_LD;
            end

            S_POP_LD:
            begin
                mov_next   = rd_a_reg;
                pos_next   = '0;
                state_next = S_DN_REQ;
            end

            S_DN_REQ:
            begin
                if (l_idx >= cnt_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    l_next     = l_idx[AW-1:0];
                    r_next     = r_idx[AW-1:0];
                    has_r_next = (r_idx < cnt_ext);
                    rd_a_addr  = l_idx[AW-1:0];
                    rd_b_addr  = has_r_next ? r_idx[AW-1:0] : l_idx[AW-1:0];
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (pick.key <= mov_reg.key)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    wr_data    = pick;
                    pos_next   = pick_idx;
                    state_next = S_DN_REQ;
                end
            end

            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        par_reg    <= par_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        has_r_reg  <= has_r_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        mov_reg    <= mov_next;
        res_reg    <= res_next;
        if (wr_en && (wr_addr == '0))
        begin
            root_reg <= wr_data;
        end
        if (emit)
        begin
            if (op_reg == mhpq_pkg::OP_INSERT)
            begin
                rsp_reg.out_key <= root_reg.key;
                rsp_reg.out_val <= root_reg.val;
            end
            else
            begin
                rsp_reg.out_key <= res_reg.key;
                rsp_reg.out_val <= res_reg.val;
            end
            rsp_reg.entry_count <= mhpq_pkg::COUNT_WIDTH'(count_reg);
            rsp_reg.status      <= status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every entry written belongs to the live part of the heap.
    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) < count_reg))
        else $error("heap write beyond the live entries");

    // The heap memory is never written while waiting for a command or a result slot.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT) |-> !wr_en)
        else $error("heap write outside a sift");

    // A new result appears only after the sequencer has finished an operation.
    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result loaded outside the emit state");

    // An accepted insert into a heap with room grows it by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (head_pop && head.op == mhpq_pkg::OP_INSERT && count_reg != CW'(CAPACITY))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the heap");

endmodule
